@@ rtl/core/mexp_pkg.sv @@
package mexp_pkg;

  localparam int EXP_W     = 16;
  localparam int MOD_REG_W = 16;
  localparam int MSG_W     = 31;
  localparam int RES_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MSG_CNT_W = $clog2(MSG_W);

  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/mexp_in_if.sv @@
interface mexp_in_if;
  logic                        valid;
  logic                        ready;
  logic [mexp_pkg::MSG_W-1:0]  message;

  modport source (output valid, output message, input ready);
  modport sink (input valid, input message, output ready);
endinterface

@@ rtl/core/mexp_out_if.sv @@
interface mexp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mexp_pkg::RES_W-1:0]  result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

@@ rtl/core/mexp_mulmod.sv @@
// bit-serial interleaved modular multiply, one multiplier bit per cycle, msb first
module mexp_mulmod #(
  parameter int WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] n_i,
  output logic             done_o,
  output logic [WIDTH-1:0] product_o
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] r_q, r_d;

  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] sum_red;

  // r = (2r mod n + bit*a) mod n, operands stay below n
  always_comb begin
    dbl = {r_q, 1'b0};
    if (dbl >= {1'b0, n_i}) begin
      dbl = dbl - {1'b0, n_i};
    end
    dbl_red = dbl[WIDTH-1:0];
    sum = {1'b0, dbl_red} + (b_q[WIDTH-1] ? {1'b0, a_q} : '0);
    if (sum >= {1'b0, n_i}) begin
      sum = sum - {1'b0, n_i};
    end
    sum_red = sum[WIDTH-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (busy_q) begin
      r_d = sum_red;
      b_d = {b_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
      cnt_d  = CNT_W'(WIDTH - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o    = done_q;
  assign product_o = r_q;

endmodule

@@ rtl/core/modular_exponentiation_core.sv @@
// sequence: the message is first reduced mod n bit-serially, then for each exponent bit,
//   lsb first, a multiply into the result when the bit is set, then a square, both on the
//   W-bit multiplier, W = min(MODULUS_WIDTH, 16); the result is then registered
// flow: one message at a time, set by the single bit-serial modular multiplier; the next
//   message is taken in the idle cycle after the result register loads, later while it waits
// reset: exponent and modulus registers return to 1, the sequencer idles, no result pending
module modular_exponentiation_core #(
  parameter int MODULUS_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mexp_pkg::MOD_REG_W-1:0]  cfg_data_i,
  mexp_in_if.sink                         msg_i,
  mexp_out_if.source                      res_o
);

  localparam int NW = (MODULUS_WIDTH < mexp_pkg::MOD_REG_W) ? MODULUS_WIDTH
                                                             : mexp_pkg::MOD_REG_W;

  mexp_pkg::state_e state_q, state_d;

  logic [mexp_pkg::EXP_W-1:0]     exp_q;
  logic [NW-1:0]                  mod_q;
  logic [mexp_pkg::EXP_W-1:0]     e_q;
  logic [mexp_pkg::MSG_W-1:0]     m_q;
  logic [mexp_pkg::MSG_CNT_W-1:0] mcnt_q;
  logic [NW-1:0]                  rr_q;
  logic [NW-1:0]                  acc_q;
  logic [NW-1:0]                  sq_q;
  logic                           out_valid_q;
  logic [mexp_pkg::RES_W-1:0]     out_data_q;

  logic          in_xfer;
  logic          out_xfer;
  logic          load_out;
  logic          mul_start;
  logic          mul_done;
  logic [NW-1:0] mul_a;
  logic [NW-1:0] mul_prod;
  logic [NW:0]   rr_ext;
  logic [NW-1:0] rr_next;

  assign in_xfer  = msg_i.valid && msg_i.ready;
  assign out_xfer = out_valid_q && res_o.ready;

  // message mod n, one message bit per cycle
  always_comb begin
    rr_ext = {rr_q, m_q[mexp_pkg::MSG_W-1]};
    if (rr_ext >= {1'b0, mod_q}) begin
      rr_ext = rr_ext - {1'b0, mod_q};
    end
    rr_next = rr_ext[NW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE:    if (in_xfer) state_d = mexp_pkg::ST_REDUCE;
      mexp_pkg::ST_REDUCE:  if (mcnt_q == '0) state_d = mexp_pkg::ST_BIT;
      mexp_pkg::ST_BIT: begin
        priority if (e_q == '0) state_d = mexp_pkg::ST_DONE;
        else if (e_q[0]) state_d = mexp_pkg::ST_MUL_ACC;
        else state_d = mexp_pkg::ST_MUL_SQ;
      end
      mexp_pkg::ST_MUL_ACC: if (mul_done) state_d = mexp_pkg::ST_MUL_SQ;
      mexp_pkg::ST_MUL_SQ:  if (mul_done) state_d = mexp_pkg::ST_BIT;
      mexp_pkg::ST_DONE:    if (!out_valid_q || res_o.ready) state_d = mexp_pkg::ST_IDLE;
      default:              state_d = mexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    msg_i.ready = 1'b0;
    mul_start   = 1'b0;
    mul_a       = sq_q;
    load_out    = 1'b0;
    unique case (state_q)
      mexp_pkg::ST_IDLE:    msg_i.ready = 1'b1;
      mexp_pkg::ST_REDUCE:  ;
      mexp_pkg::ST_BIT: begin
        if (e_q != '0) begin
          mul_start = 1'b1;
          if (e_q[0]) mul_a = acc_q;
        end
      end
      mexp_pkg::ST_MUL_ACC: mul_start = mul_done;
      mexp_pkg::ST_MUL_SQ:  ;
      mexp_pkg::ST_DONE:    load_out = !out_valid_q || res_o.ready;
      default:              ;
    endcase
  end

  mexp_mulmod #(
    .WIDTH (NW)
  ) u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (sq_q),
    .n_i       (mod_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      exp_q       <= mexp_pkg::EXP_W'(1);
      mod_q       <= NW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == mexp_pkg::CFG_EXPONENT) begin
        exp_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == mexp_pkg::CFG_MODULUS) begin
        mod_q <= cfg_data_i[NW-1:0];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        m_q    <= msg_i.message;
        rr_q   <= '0;
        mcnt_q <= mexp_pkg::MSG_CNT_W'(mexp_pkg::MSG_W - 1);
        // exponent zero behaves as exponent one
        e_q    <= (exp_q == '0) ? mexp_pkg::EXP_W'(1) : exp_q;
      end
      mexp_pkg::ST_REDUCE: begin
        m_q    <= {m_q[mexp_pkg::MSG_W-2:0], 1'b0};
        rr_q   <= rr_next;
        mcnt_q <= mcnt_q - 1'b1;
        if (mcnt_q == '0) begin
          sq_q  <= rr_next;
          acc_q <= (mod_q == NW'(1)) ? '0 : NW'(1);
        end
      end
      mexp_pkg::ST_BIT:     ;
      mexp_pkg::ST_MUL_ACC: if (mul_done) acc_q <= mul_prod;
      mexp_pkg::ST_MUL_SQ: begin
        if (mul_done) begin
          sq_q <= mul_prod;
          e_q  <= {1'b0, e_q[mexp_pkg::EXP_W-1:1]};
        end
      end
      mexp_pkg::ST_DONE: begin
        // a zero modulus gives zero
        if (load_out) begin
          out_data_q <= (mod_q == '0) ? '0 : mexp_pkg::RES_W'(acc_q);
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.result = out_data_q;

endmodule

@@ verif/modular_exponentiation_core_checker.sv @@
`timescale 1ns / 1ps
module modular_exponentiation_core_checker #(
  parameter int MODULUS_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mexp_pkg::MOD_REG_W-1:0]  cfg_data_i,
  input  logic                            msg_valid_i,
  input  logic                            msg_ready_i,
  input  logic [mexp_pkg::MSG_W-1:0]      msg_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [mexp_pkg::RES_W-1:0]      res_i,
  output int                              errors_o,
  output int                              pending_o
);

  localparam int MAX_REPORTS = 10;
  localparam logic [mexp_pkg::MOD_REG_W-1:0] MOD_MASK =
    mexp_pkg::MOD_REG_W'((64'd1 << MODULUS_WIDTH) - 64'd1);

  logic [mexp_pkg::EXP_W-1:0]     exponent_q;
  logic [mexp_pkg::MOD_REG_W-1:0] modulus_q;

  logic [mexp_pkg::RES_W-1:0]     expected_results[$];
  logic [mexp_pkg::RES_W-1:0]     wanted;
  int                             mismatches;

  // square-and-multiply over the exponent bits, every product at full width
  function automatic logic [mexp_pkg::RES_W-1:0] modexp_predict(
    input logic [mexp_pkg::MSG_W-1:0] msg
  );
    logic [31:0]                prod;
    logic [mexp_pkg::RES_W-1:0] acc;
    logic [mexp_pkg::RES_W-1:0] sq;
    logic [mexp_pkg::EXP_W-1:0] e;
    if (modulus_q == '0) begin
      // no reduction possible
      return '0;
    end
    sq  = mexp_pkg::RES_W'(msg % mexp_pkg::MSG_W'(modulus_q));
    e   = (exponent_q == '0) ? mexp_pkg::EXP_W'(1) : exponent_q;
    acc = mexp_pkg::RES_W'(mexp_pkg::RES_W'(1) % modulus_q);
    while (e != '0) begin
      if (e[0]) begin
        prod = 32'(acc) * 32'(sq);
        acc  = mexp_pkg::RES_W'(prod % 32'(modulus_q));
      end
      prod = 32'(sq) * 32'(sq);
      sq   = mexp_pkg::RES_W'(prod % 32'(modulus_q));
      e    = e >> 1;
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q = mexp_pkg::EXP_W'(1);
      modulus_q  = mexp_pkg::MOD_REG_W'(1);
      mismatches = 0;
      expected_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (msg_valid_i && msg_ready_i) begin
        expected_results = {expected_results, modexp_predict(msg_i)};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mexp_pkg::CFG_EXPONENT: exponent_q = cfg_data_i[mexp_pkg::EXP_W-1:0];
          mexp_pkg::CFG_MODULUS:  modulus_q  = cfg_data_i & MOD_MASK;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result transfer: result=%0d", res_i);
          end
        end else begin
          wanted = expected_results.pop_front();
          if (wanted !== res_i) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result mismatch: expected=%0d actual=%0d", wanted, res_i);
            end
          end
        end
      end
      errors_o  <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

@@ verif/modular_exponentiation_core_tb.sv @@
`timescale 1ns / 1ps
module modular_exponentiation_core_tb;

  localparam int          MODULUS_WIDTH = 16;
  localparam int unsigned CYCLE_LIMIT   = 8_000_000;
  localparam int          TAIL_CYCLES   = 1000;
  localparam int          RANDOM_ITEMS  = 950;

  // indexes past the register list, writes there must be ignored
  localparam logic [mexp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [mexp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [mexp_pkg::MSG_W-1:0] MSG_MAX = {mexp_pkg::MSG_W{1'b1}};

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mexp_pkg::MOD_REG_W-1:0] cfg_data;

  mexp_in_if  msg_if();
  mexp_out_if res_if();

  int          errors;
  int          pending;
  int unsigned cycles = 0;
  bit          steady_flow;
  int          ready_hold;
  int          sent;
  int          phase_len;
  logic [mexp_pkg::EXP_W-1:0]     exp_sel;
  logic [mexp_pkg::MOD_REG_W-1:0] mod_sel;
  logic [mexp_pkg::MSG_W-1:0]     msg_sel;

  modular_exponentiation_core #(
    .MODULUS_WIDTH(MODULUS_WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .msg_i      (msg_if),
    .res_o      (res_if)
  );

  modular_exponentiation_core_checker #(
    .MODULUS_WIDTH(MODULUS_WIDTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .msg_valid_i (msg_if.valid),
    .msg_ready_i (msg_if.ready),
    .msg_i       (msg_if.message),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_i       (res_if.result),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result back-pressure: short stalls mostly, now and then a long one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ready_hold   <= 0;
      res_if.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold   <= ready_hold - 1;
      res_if.ready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
      ready_hold   <= ($urandom_range(0, 15) == 0) ? $urandom_range(40, 300)
                                                   : $urandom_range(0, 4);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic cfg_write(input logic [mexp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mexp_pkg::MOD_REG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // returns at the rising edge of the transfer, valid stays high
  task automatic send_message(input logic [mexp_pkg::MSG_W-1:0] msg);
    int gap;
    gap = 0;
    if (!steady_flow) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 600) : $urandom_range(0, 3);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      msg_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    msg_if.valid   <= 1'b1;
    msg_if.message <= msg;
    do begin
      @(posedge clk_i);
    end while (!msg_if.ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    msg_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = mexp_pkg::CFG_EXPONENT;
    cfg_data       = '0;
    msg_if.valid   = 1'b0;
    msg_if.message = '0;
    steady_flow    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: modulus one gives zero
    send_message('0);
    send_message(MSG_MAX);
    drain_results();

    // exponent zero behaves as exponent one
    cfg_write(mexp_pkg::CFG_EXPONENT, 16'd0);
    cfg_write(mexp_pkg::CFG_MODULUS, 16'hFFFF);
    send_message('0);
    send_message(MSG_MAX);
    send_message(mexp_pkg::MSG_W'(16'hFFFF));
    send_message(mexp_pkg::MSG_W'(16'hFFFE));
    drain_results();

    cfg_write(mexp_pkg::CFG_EXPONENT, 16'hFFFF);
    send_message(MSG_MAX);
    send_message(mexp_pkg::MSG_W'(2));
    drain_results();

    // small textbook key pair
    cfg_write(mexp_pkg::CFG_EXPONENT, 16'd17);
    cfg_write(mexp_pkg::CFG_MODULUS, 16'd3233);
    send_message(mexp_pkg::MSG_W'(65));
    drain_results();
    cfg_write(mexp_pkg::CFG_EXPONENT, 16'd2753);
    send_message(mexp_pkg::MSG_W'(2790));
    drain_results();

    // modulus zero gives zero
    cfg_write(mexp_pkg::CFG_MODULUS, 16'd0);
    send_message(mexp_pkg::MSG_W'(12345));
    drain_results();

    cfg_write(mexp_pkg::CFG_EXPONENT, 16'd3);
    cfg_write(mexp_pkg::CFG_MODULUS, 16'd1000);
    cfg_write(CFG_SPARE_A, 16'hA5A5);
    cfg_write(CFG_SPARE_B, 16'h5A5A);
    send_message(mexp_pkg::MSG_W'(7));
    drain_results();

    cfg_write(mexp_pkg::CFG_EXPONENT, 16'd1);
    cfg_write(mexp_pkg::CFG_MODULUS, 16'hFFFF);
    send_message(mexp_pkg::MSG_W'(32'h5555_5555));
    send_message(mexp_pkg::MSG_W'(32'h2AAA_AAAA));
    drain_results();

    cfg_write(mexp_pkg::CFG_EXPONENT, 16'hFFFF);
    cfg_write(mexp_pkg::CFG_MODULUS, 16'd1);
    send_message(mexp_pkg::MSG_W'(99));
    drain_results();
    cfg_write(mexp_pkg::CFG_MODULUS, 16'h8000);
    send_message(MSG_MAX);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len   = $urandom_range(20, 80);
      steady_flow = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       exp_sel = 16'd0;
        1:       exp_sel = 16'd1;
        2:       exp_sel = 16'hFFFF;
        3, 4:    exp_sel = mexp_pkg::EXP_W'($urandom_range(2, 255));
        default: exp_sel = mexp_pkg::EXP_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 15))
        0:       mod_sel = 16'd0;
        1:       mod_sel = 16'd1;
        2, 3:    mod_sel = 16'hFFFF;
        4, 5, 6: mod_sel = mexp_pkg::MOD_REG_W'($urandom_range(2, 255));
        default: mod_sel = mexp_pkg::MOD_REG_W'($urandom_range(2, 65535));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(mexp_pkg::CFG_EXPONENT, exp_sel);
        cfg_write(mexp_pkg::CFG_MODULUS, mod_sel);
      end else begin
        cfg_write(mexp_pkg::CFG_MODULUS, mod_sel);
        cfg_write(mexp_pkg::CFG_EXPONENT, exp_sel);
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                  mexp_pkg::MOD_REG_W'($urandom));
      end
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        case ($urandom_range(0, 7))
          0:       msg_sel = '0;
          1:       msg_sel = MSG_MAX;
          2:       msg_sel = mexp_pkg::MSG_W'($urandom_range(0, 255));
          3:       msg_sel = mexp_pkg::MSG_W'(32'(mod_sel) * $urandom_range(0, 32767));
          4:       msg_sel = mexp_pkg::MSG_W'(mod_sel - 16'd1);
          default: msg_sel = mexp_pkg::MSG_W'($urandom);
        endcase
        send_message(msg_sel);
        sent++;
      end
      drain_results();
    end

    steady_flow = 1'b1;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
